[sv/b64d_pkg.sv]
package b64d_pkg;

  localparam int MaxResults = 4;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharDigit9 = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharEquals = 8'h3D;

  typedef enum logic [1:0] {
    PH_DECODING,
    PH_EQUALS,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       bad_input;
  } result_t;

  // Returns {valid, value}; valid is low outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] r;
    r = '0;
    if (ch >= CharUpperA && ch <= CharUpperZ) begin
      r = {1'b1, 6'(ch - CharUpperA)};
    end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
      r = {1'b1, 6'(ch - CharLowerA + 8'd26)};
    end else if (ch >= CharDigit0 && ch <= CharDigit9) begin
      r = {1'b1, 6'(ch - CharDigit0 + 8'd52)};
    end else if (ch == CharPlus) begin
      r = {1'b1, 6'd62};
    end else if (ch == CharSlash) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

[sv/base64_stream_decoder_top.sv]
// Results are registered in the output bundle, or the pending one while it is busy.
// Throughput: one character per cycle when s_tready is high; a character yields zero
// to four result beats, and the single result port drains one beat per cycle while
// m_tready is high, so the output sets the pace. A pending bundle register lets the
// next character in while results still wait. Reset: rst is synchronous and active
// high; it returns the decoder to the start of a text and empties both result bundles.
module base64_stream_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] character
  input  logic        s_tlast,   // final_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data_byte, [8] bad_input, [15:9] zero
  output logic        m_tuser,   // kind
  output logic        m_tlast    // run_end
);

  b64d_pkg::phase_t phase, phase_mid, phase_next;
  logic [1:0]  group_fill, fill_mid, group_fill_next;
  logic [17:0] sextet_store, store_mid, sextet_store_next;

  logic [6:0]  sx;
  logic        is_alpha, is_eq, accept;
  logic [5:0]  sval;
  logic [23:0] word;
  logic        full_group, flush;
  logic [1:0]  nbytes;
  logic [7:0]  bytes [3];
  logic [2:0]  nres;
  b64d_pkg::result_t res_new [b64d_pkg::MaxResults];

  b64d_pkg::result_t out_res [b64d_pkg::MaxResults];
  b64d_pkg::result_t pend_res [b64d_pkg::MaxResults];
  logic [1:0] out_last, out_idx, pend_last;
  logic       out_valid, pend_valid;
  logic       out_pop, out_free, new_bundle;

  assign sx       = b64d_pkg::sextet_of(s_tdata);
  assign is_alpha = sx[6];
  assign sval     = sx[5:0];
  assign is_eq    = (s_tdata == b64d_pkg::CharEquals);
  assign word     = {sextet_store, sval};
  assign s_tready = !pend_valid;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    phase_mid = phase;
    unique case (phase)
      b64d_pkg::PH_DECODING: begin
        if (!is_alpha) begin
          phase_mid = is_eq ? b64d_pkg::PH_EQUALS : b64d_pkg::PH_ERROR;
        end
      end
      b64d_pkg::PH_EQUALS: begin
        if (is_alpha) begin
          phase_mid = b64d_pkg::PH_DONE;
        end else if (!is_eq) begin
          phase_mid = b64d_pkg::PH_ERROR;
        end
      end
      default: phase_mid = phase;
    endcase
    phase_next = s_tlast ? b64d_pkg::PH_DECODING : phase_mid;
  end

  always_comb begin
    fill_mid   = group_fill;
    store_mid  = sextet_store;
    full_group = 1'b0;
    flush      = 1'b0;
    if (phase == b64d_pkg::PH_DECODING && is_alpha) begin
      if (group_fill == 2'd3) begin
        full_group = 1'b1;
        fill_mid   = 2'd0;
        store_mid  = '0;
      end else begin
        store_mid = {sextet_store[11:0], sval};
        fill_mid  = group_fill + 2'd1;
      end
    end
    if (phase == b64d_pkg::PH_EQUALS && is_alpha) begin
      flush = 1'b1;
    end
    if (s_tlast && (phase_mid == b64d_pkg::PH_DECODING || phase_mid == b64d_pkg::PH_EQUALS)) begin
      flush = 1'b1;
    end

    nbytes   = 2'd0;
    bytes[0] = word[23:16];
    bytes[1] = word[15:8];
    bytes[2] = word[7:0];
    if (full_group) begin
      nbytes = 2'd3;
    end else if (flush) begin
      if (fill_mid == 2'd2) begin
        nbytes   = 2'd1;
        bytes[0] = store_mid[11:4];
      end else if (fill_mid == 2'd3) begin
        nbytes   = 2'd2;
        bytes[0] = store_mid[17:10];
        bytes[1] = store_mid[9:2];
      end
    end

    group_fill_next   = fill_mid;
    sextet_store_next = store_mid;
    if (flush || s_tlast) begin
      group_fill_next   = 2'd0;
      sextet_store_next = '0;
    end

    nres = {1'b0, nbytes} + {2'b00, s_tlast};
    for (int i = 0; i < b64d_pkg::MaxResults; i++) begin
      if (i < 3 && 2'(i) < nbytes) begin
        res_new[i] = '{kind: 1'b0, data_byte: bytes[(i < 3) ? i : 0], bad_input: 1'b0};
      end else begin
        res_new[i] = '{kind: 1'b1, data_byte: 8'd0,
                       bad_input: (phase_mid == b64d_pkg::PH_ERROR)};
      end
    end
  end

  assign new_bundle = accept && (nres != 3'd0);
  assign out_pop    = m_tvalid && m_tready;
  assign out_free   = !out_valid || (out_pop && out_idx == out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= b64d_pkg::PH_DECODING;
      group_fill   <= 2'd0;
      sextet_store <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      group_fill   <= group_fill_next;
      sextet_store <= sextet_store_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      out_idx    <= 2'd0;
    end else if (out_free) begin
      out_idx <= 2'd0;
      if (pend_valid) begin
        out_valid  <= 1'b1;
        out_res    <= pend_res;
        out_last   <= pend_last;
        pend_valid <= 1'b0;
      end else if (new_bundle) begin
        out_valid <= 1'b1;
        out_res   <= res_new;
        out_last  <= 2'(nres - 3'd1);
      end else begin
        out_valid <= 1'b0;
      end
    end else begin
      if (out_pop) begin
        out_idx <= out_idx + 2'd1;
      end
      if (new_bundle) begin
        pend_valid <= 1'b1;
        pend_res   <= res_new;
        pend_last  <= 2'(nres - 3'd1);
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res[out_idx].bad_input, out_res[out_idx].data_byte};
  assign m_tuser  = out_res[out_idx].kind;
  assign m_tlast  = (out_idx == out_last);

endmodule
